FILE: rtl/cpq_pkg.sv
package cpq_pkg;

    localparam int QUEUE_DEPTH = 128;

    localparam int ID_W    = 16;
    localparam int CLASS_W = 2;
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 8;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 64;

    typedef enum logic {
        REQ_PUSH = 1'b0,
        REQ_POP  = 1'b1
    } t_req;

    typedef struct packed {
        logic [TIME_W-1:0]  arrival_time;
        logic [CLASS_W-1:0] entry_class;
        logic [ID_W-1:0]    entry_id;
    } t_entry;

    typedef struct packed {
        logic   push_en;
        logic   pop_en;
        t_entry fresh;
    } t_cell_ctrl;

endpackage

FILE: rtl/class_then_age_priority_queue_core.sv
// the result transaction is registered and appears in the cycle after the request transaction is accepted
// throughput: one request per cycle, push or pop; every cell compares and shifts in parallel
// a stalled result register holds off new requests until it is taken
// reset (synchronous, active low) clears the count, the cell valid bits and the output valid
// entry payloads are not reset and are never read before being written
module class_then_age_priority_queue_core #(
    parameter int QUEUE_DEPTH = cpq_pkg::QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // entry_id, entry_class, arrival_time, zero pad
    input  logic [cpq_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // req_type
    input  logic                           i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // pop_valid, head_id, head_class, head_time, push_dropped, queue_empty, queue_count, zero pad
    output logic [cpq_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cpq_pkg::t_entry     c_data  [QUEUE_DEPTH];
    logic                c_valid [QUEUE_DEPTH];
    logic                c_ins   [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_valid_vec;

    cpq_pkg::t_cell_ctrl w_ctrl;
    cpq_pkg::t_entry     w_fresh;
    logic                w_accept;
    logic                w_is_pop;
    logic                w_full;
    logic                w_empty;

    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                r_out_valid;
    logic [cpq_pkg::OUT_DATA_W-1:0] r_out_data;
    logic [cpq_pkg::OUT_DATA_W-1:0] n_out_data;
    logic [CW+7:0]       w_count_ext;
    cpq_pkg::t_entry     w_head;
    logic                w_pop_valid;
    logic                w_dropped;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_is_pop        = (cpq_pkg::t_req'(i_s_axis_tuser) == cpq_pkg::REQ_POP);
    assign w_full          = (r_count == CW'(QUEUE_DEPTH));
    assign w_empty         = (r_count == '0);

    assign w_fresh.entry_id     = i_s_axis_tdata[15:0];
    assign w_fresh.entry_class  = i_s_axis_tdata[17:16];
    assign w_fresh.arrival_time = i_s_axis_tdata[49:18];

    assign w_ctrl.push_en = w_accept && !w_is_pop && !w_full;
    assign w_ctrl.pop_en  = w_accept && w_is_pop && !w_empty;
    assign w_ctrl.fresh   = w_fresh;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            cpq_pkg::t_entry w_left_data;
            logic            w_left_valid;
            logic            w_left_ins;
            cpq_pkg::t_entry w_right_data;
            logic            w_right_valid;

            if (g == 0) begin : g_first
                assign w_left_data  = w_fresh;
                assign w_left_valid = 1'b1;
                assign w_left_ins   = 1'b0;
            end else begin : g_mid
                assign w_left_data  = c_data[g-1];
                assign w_left_valid = c_valid[g-1];
                assign w_left_ins   = c_ins[g-1];
            end

            if (g == QUEUE_DEPTH - 1) begin : g_last
                assign w_right_data  = '0;
                assign w_right_valid = 1'b0;
            end else begin : g_inner
                assign w_right_data  = c_data[g+1];
                assign w_right_valid = c_valid[g+1];
            end

            cpq_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctrl        (w_ctrl),
                .i_left_data   (w_left_data),
                .i_left_valid  (w_left_valid),
                .i_left_ins    (w_left_ins),
                .i_right_data  (w_right_data),
                .i_right_valid (w_right_valid),
                .o_data        (c_data[g]),
                .o_valid       (c_valid[g]),
                .o_ins         (c_ins[g])
            );

            assign w_valid_vec[g] = c_valid[g];
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (w_ctrl.push_en) begin
            n_count = r_count + CW'(1);
        end else if (w_ctrl.pop_en) begin
            n_count = r_count - CW'(1);
        end
    end

    assign w_pop_valid = w_ctrl.pop_en;
    assign w_dropped   = w_accept && !w_is_pop && w_full;
    assign w_head      = w_pop_valid ? c_data[0] : '0;
    assign w_count_ext = {8'd0, n_count};

    always_comb begin
        n_out_data        = '0;
        n_out_data[0]     = w_pop_valid;
        n_out_data[16:1]  = w_head.entry_id;
        n_out_data[18:17] = w_head.entry_class;
        n_out_data[50:19] = w_head.arrival_time;
        n_out_data[51]    = w_dropped;
        n_out_data[52]    = (n_count == '0);
        n_out_data[60:53] = w_count_ext[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("count above depth");

    a_valid_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid_vec) == int'(r_count))
        else $error("cell valid bits disagree with count");

    a_drop_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dropped |-> w_full)
        else $error("push dropped while not full");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.push_en |=> r_count == $past(r_count) + CW'(1))
        else $error("push did not grow the queue");

    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.pop_en |-> c_valid[0])
        else $error("pop from invalid head cell");

endmodule

FILE: rtl/cpq_cell.sv
module cpq_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cpq_pkg::t_cell_ctrl i_ctrl,
    input  cpq_pkg::t_entry     i_left_data,
    input  logic                i_left_valid,
    input  logic                i_left_ins,
    input  cpq_pkg::t_entry     i_right_data,
    input  logic                i_right_valid,
    output cpq_pkg::t_entry     o_data,
    output logic                o_valid,
    output logic                o_ins
);

    cpq_pkg::t_entry r_data;
    logic            r_valid;
    logic            w_before;

    // fresh entry ranks ahead of the one held here
    always_comb begin
        if (i_ctrl.fresh.entry_class != r_data.entry_class) begin
            w_before = i_ctrl.fresh.entry_class > r_data.entry_class;
        end else begin
            w_before = i_ctrl.fresh.arrival_time < r_data.arrival_time;
        end
    end

    assign o_ins   = !r_valid || w_before;
    assign o_data  = r_data;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.push_en) begin
            if (i_left_valid) begin
                r_valid <= 1'b1;
            end
        end else if (i_ctrl.pop_en) begin
            r_valid <= i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push_en) begin
            if (o_ins && i_left_valid) begin
                r_data <= i_left_ins ? i_left_data : i_ctrl.fresh;
            end
        end else if (i_ctrl.pop_en) begin
            r_data <= i_right_data;
        end
    end

endmodule

FILE: verif/tb_class_then_age_priority_queue_core.sv
module tb_class_then_age_priority_queue_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH = cpq_pkg::QUEUE_DEPTH;
    localparam int ID_W        = cpq_pkg::ID_W;
    localparam int CLASS_W     = cpq_pkg::CLASS_W;
    localparam int TIME_W      = cpq_pkg::TIME_W;
    localparam int COUNT_W     = cpq_pkg::COUNT_W;
    localparam int IN_DATA_W   = cpq_pkg::IN_DATA_W;
    localparam int OUT_DATA_W  = cpq_pkg::OUT_DATA_W;

    typedef struct {
        logic                pop_valid;
        logic [ID_W-1:0]     head_id;
        logic [CLASS_W-1:0]  head_class;
        logic [TIME_W-1:0]   head_time;
        logic                push_dropped;
        logic                queue_empty;
        logic [COUNT_W-1:0]  queue_count;
    } t_reply;

    class class_age_scoreboard;
        cpq_pkg::t_entry ranked_entries[$];
        t_reply          expected_replies[$];
        int              mismatches;

        function bit outranks(cpq_pkg::t_entry fresh, cpq_pkg::t_entry held);
            if (fresh.entry_class != held.entry_class) begin
                return fresh.entry_class > held.entry_class;
            end
            return fresh.arrival_time < held.arrival_time;
        endfunction

        // update the sorted model and queue the reply this request causes
        function void note_request(cpq_pkg::t_req req, cpq_pkg::t_entry ent);
            t_reply r;
            int     pos;
            r.pop_valid    = 1'b0;
            r.head_id      = '0;
            r.head_class   = '0;
            r.head_time    = '0;
            r.push_dropped = 1'b0;
            if (req == cpq_pkg::REQ_PUSH) begin
                if (ranked_entries.size() >= QUEUE_DEPTH) begin
                    r.push_dropped = 1'b1;
                end else begin
                    pos = ranked_entries.size();
                    while (pos > 0 && outranks(ent, ranked_entries[pos-1])) begin
                        pos--;
                    end
                    ranked_entries.insert(pos, ent);
                end
            end else if (ranked_entries.size() > 0) begin
                r.pop_valid  = 1'b1;
                r.head_id    = ranked_entries[0].entry_id;
                r.head_class = ranked_entries[0].entry_class;
                r.head_time  = ranked_entries[0].arrival_time;
                void'(ranked_entries.pop_front());
            end
            r.queue_empty = (ranked_entries.size() == 0);
            r.queue_count = COUNT_W'(ranked_entries.size());
            expected_replies.push_back(r);
        endfunction

        task report_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want) begin
                mismatches++;
                $display("mismatch on %s: got 0x%0h, expected 0x%0h", name, got, want);
            end
        endtask

        task check_result(logic [OUT_DATA_W-1:0] d);
            t_reply want;
            if (expected_replies.size() == 0) begin
                report_field("unexpected result transaction", 64'd1, 64'd0);
                return;
            end
            want = expected_replies.pop_front();
            report_field("pop_valid",    64'(d[0]),     64'(want.pop_valid));
            report_field("head_id",      64'(d[16:1]),  64'(want.head_id));
            report_field("head_class",   64'(d[18:17]), 64'(want.head_class));
            report_field("head_time",    64'(d[50:19]), 64'(want.head_time));
            report_field("push_dropped", 64'(d[51]),    64'(want.push_dropped));
            report_field("queue_empty",  64'(d[52]),    64'(want.queue_empty));
            report_field("queue_count",  64'(d[60:53]), 64'(want.queue_count));
        endtask
    endclass

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata  = '0;
    logic                  i_s_axis_tuser  = 1'b0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    class_age_scoreboard order_check = new();

    bit tx_idle_on      = 1'b1;
    bit rx_idle_on      = 1'b1;
    bit rst_done        = 1'b0;
    int rx_hold_request = 0;
    int request_total   = 0;

    class_then_age_priority_queue_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            order_check.check_result(o_m_axis_tdata);
        end
    end

    // result side: random stall before each transaction, or a long hold-off on request
    initial begin : result_sink
        int wait_cycles;
        wait (rst_done);
        forever begin
            wait_cycles = rx_idle_on ? $urandom_range(0, 9) : 0;
            if (rx_hold_request > 0) begin
                wait_cycles     = rx_hold_request;
                rx_hold_request = 0;
            end
            if (wait_cycles > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid) @(posedge i_clk);
        end
    end

    task send_request(input cpq_pkg::t_req req, input cpq_pkg::t_entry ent);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(IN_DATA_W - $bits(cpq_pkg::t_entry)){1'b0}}, ent};
        i_s_axis_tuser  <= req;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        order_check.note_request(req, ent);
        request_total++;
    endtask

    task send_push(input logic [ID_W-1:0] id, input logic [CLASS_W-1:0] cls,
                   input logic [TIME_W-1:0] stamp);
        cpq_pkg::t_entry ent;
        ent.entry_id     = id;
        ent.entry_class  = cls;
        ent.arrival_time = stamp;
        send_request(cpq_pkg::REQ_PUSH, ent);
    endtask

    task wait_for_replies(input int limit);
        int cycles;
        cycles = 0;
        if (order_check.expected_replies.size() > 0) begin
            i_s_axis_tvalid <= 1'b0;
        end
        while (order_check.expected_replies.size() > 0 && cycles < limit) begin
            @(posedge i_clk);
            cycles++;
        end
    endtask

    // time_mode 1 crowds stamps together for ties, mode 2 favors the extremes
    function cpq_pkg::t_entry random_entry(int time_mode);
        cpq_pkg::t_entry ent;
        ent.entry_id    = ID_W'($urandom);
        ent.entry_class = CLASS_W'($urandom_range(0, 3));
        case (time_mode)
            1: begin
                ent.arrival_time = TIME_W'($urandom_range(0, 15));
            end
            2: begin
                case ($urandom_range(0, 2))
                    0: ent.arrival_time = '0;
                    1: ent.arrival_time = '1;
                    default: ent.arrival_time = TIME_W'($urandom);
                endcase
            end
            default: begin
                ent.arrival_time = TIME_W'($urandom);
            end
        endcase
        return ent;
    endfunction

    task run_phase(input int len, input int push_pct, input int time_mode);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 99) < push_pct) begin
                send_request(cpq_pkg::REQ_PUSH, random_entry(time_mode));
            end else begin
                send_request(cpq_pkg::REQ_POP, random_entry(time_mode));
            end
        end
    endtask

    initial begin
        int mode;
        repeat (3) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done  = 1'b1;
        @(posedge i_clk);

        // directed: empty pop, field extremes, ties within a class, full ordering
        send_request(cpq_pkg::REQ_POP, random_entry(0));
        send_push(16'hFFFF, 2'd0, 32'hFFFF_FFFF);
        send_push(16'h0000, 2'd3, 32'h0000_0000);
        send_push(16'h1234, 2'd3, 32'h0000_0000);
        send_push(16'hA5A5, 2'd1, 32'd7);
        send_push(16'h5A5A, 2'd2, 32'h8000_0000);
        send_push(16'h0001, 2'd1, 32'd7);
        send_push(16'h0002, 2'd1, 32'd6);
        send_push(16'h7FFF, 2'd2, 32'h7FFF_FFFF);
        repeat (9) send_request(cpq_pkg::REQ_POP, random_entry(2));

        // long receiver hold-off while pushes keep coming, then fill past full
        tx_idle_on      = 1'b0;
        rx_hold_request = 300;
        run_phase(150, 100, 1);
        wait_for_replies(5000);
        run_phase(20, 60, 0);
        tx_idle_on = 1'b1;
        run_phase(150, 5, 2);
        wait_for_replies(5000);

        while (request_total < 950) begin
            mode       = $urandom_range(0, 3);
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            case (mode)
                1: run_phase($urandom_range(40, 160), 85, $urandom_range(0, 2));
                2: run_phase($urandom_range(20, 120), 15, $urandom_range(0, 2));
                3: begin
                    tx_idle_on = 1'b0;
                    rx_idle_on = 1'b0;
                    run_phase($urandom_range(20, 80), 50, $urandom_range(0, 2));
                end
                default: run_phase($urandom_range(20, 120), 50, $urandom_range(0, 2));
            endcase
            if ($urandom_range(0, 2) == 0) begin
                wait_for_replies(5000);
            end
        end

        wait_for_replies(20000);
        repeat (5) @(posedge i_clk);
        if (order_check.expected_replies.size() != 0) begin
            order_check.report_field("replies left over",
                                     64'(order_check.expected_replies.size()), 64'd0);
        end
        if (order_check.mismatches == 0) begin
            $display("class_then_age_priority_queue_core regression: pass");
        end else begin
            $display("class_then_age_priority_queue_core regression: fail");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("class_then_age_priority_queue_core regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
rtl/cpq_pkg.sv
rtl/cpq_cell.sv
rtl/class_then_age_priority_queue_core.sv
verif/tb_class_then_age_priority_queue_core.sv
